### design/ebfd_pkg.sv
// Shared types and constants for the escaped byte frame decoder.
// Used by the front, queue, back, top level, checker and bench files; no dependencies.
`timescale 1ns / 1ps

package ebfd_pkg;

   // Frame format
   localparam int MAX_PAYLOAD = 8;
   localparam int HDR_BYTES   = 4;
   localparam int MAX_LEN     = HDR_BYTES + MAX_PAYLOAD;
   localparam int CNT_W       = 4;
   localparam int LEN_W       = 4;
   localparam int HDR_W       = 32;
   localparam int PAY_W       = 64;
   localparam int RSP_W       = 104;

   // Special line bytes
   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] ESC_BYTE   = 8'hFE;
   localparam logic [7:0] ESC_FD     = 8'hFD;

   // Decoded symbol kinds passed from front to back
   typedef enum logic [1:0] {
      TOK_START = 2'd0,
      TOK_DATA  = 2'd1,
      TOK_ABORT = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
   } token_type;

endpackage

### design/ebfd_front.sv
// Front end: takes raw bytes, resolves escapes and classifies them into tokens.
// Depends on ebfd_pkg.
`timescale 1ns / 1ps

module ebfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [7:0]           req_tdata,
   input  logic                 space_avail,
   output logic                 push,
   output ebfd_pkg::token_type  push_token
);

   logic escape_ff;
   logic escape_in;
   logic emit;
   logic accept;

   assign accept = req_tvalid && space_avail;

   // Classify one raw byte
   always_comb begin
      escape_in        = escape_ff;
      emit             = 1'b1;
      push_token.kind  = ebfd_pkg::TOK_DATA;
      push_token.data  = req_tdata;
      if (req_tdata == ebfd_pkg::START_BYTE) begin
         push_token.kind = ebfd_pkg::TOK_START;
         escape_in       = 1'b0;
      end else if (escape_ff) begin
         escape_in = 1'b0;
         if (req_tdata == ebfd_pkg::ESC_BYTE) begin
            push_token.data = ebfd_pkg::START_BYTE;
         end else if (req_tdata == ebfd_pkg::ESC_FD) begin
            push_token.data = ebfd_pkg::ESC_BYTE;
         end else begin
            push_token.kind = ebfd_pkg::TOK_ABORT;
         end
      end else if (req_tdata == ebfd_pkg::ESC_BYTE) begin
         escape_in = 1'b1;
         emit      = 1'b0;
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else if (accept) begin
         escape_ff <= escape_in;
      end
   end

endmodule

### design/ebfd_queue.sv
// Two-entry token queue between the front and back ends.
// Depends on ebfd_pkg.
`timescale 1ns / 1ps

module ebfd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ebfd_pkg::token_type  push_token,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 not_empty,
   output ebfd_pkg::token_type  pop_token
);

   ebfd_pkg::token_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_token = entry_ff[rd_ptr_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

### design/ebfd_back.sv
// Back end: assembles frames from decoded tokens and holds the result register.
// Depends on ebfd_pkg.
`timescale 1ns / 1ps

module ebfd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tok_valid,
   input  ebfd_pkg::token_type           tok,
   output logic                          tok_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ebfd_pkg::RSP_W-1:0]    rsp_tdata
);

   logic                          in_frame_ff,  in_frame_in;
   logic [ebfd_pkg::CNT_W-1:0]    count_ff,     count_in;
   logic [ebfd_pkg::LEN_W-1:0]    length_ff,    length_in;
   logic [ebfd_pkg::HDR_W-1:0]    header_ff,    header_in;
   logic [7:0]                    store_ff [ebfd_pkg::MAX_PAYLOAD];
   logic [7:0]                    store_in [ebfd_pkg::MAX_PAYLOAD];
   logic                          out_valid_ff, out_valid_in;
   logic [ebfd_pkg::HDR_W-1:0]    out_header_ff;
   logic [ebfd_pkg::LEN_W-1:0]    out_len_ff;
   logic [ebfd_pkg::PAY_W-1:0]    out_pay_ff;
   logic [ebfd_pkg::PAY_W-1:0]    pay_vec;
   logic                          take;
   logic                          emit;

   // Pull a token whenever the result register is free or being drained
   assign tok_pop = !out_valid_ff || rsp_tready;
   assign take    = tok_pop && tok_valid;

   // Frame assembly
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      header_in   = header_ff;
      store_in    = store_ff;
      emit        = 1'b0;
      case (tok.kind)
         ebfd_pkg::TOK_START: begin
            in_frame_in = 1'b1;
            count_in    = '0;
            length_in   = '0;
            header_in   = '0;
            for (int i = 0; i < ebfd_pkg::MAX_PAYLOAD; i++) begin
               store_in[i] = 8'h00;
            end
         end
         ebfd_pkg::TOK_ABORT: begin
            in_frame_in = 1'b0;
         end
         ebfd_pkg::TOK_DATA: begin
            if (in_frame_ff) begin
               if (count_ff == '0) begin
                  // Length byte
                  if (tok.data < 8'(ebfd_pkg::HDR_BYTES) ||
                      tok.data > 8'(ebfd_pkg::MAX_LEN)) begin
                     in_frame_in = 1'b0;
                  end else begin
                     length_in = tok.data[ebfd_pkg::LEN_W-1:0];
                     count_in  = ebfd_pkg::CNT_W'(1);
                  end
               end else begin
                  for (int i = 0; i < ebfd_pkg::HDR_BYTES; i++) begin
                     if (count_ff == ebfd_pkg::CNT_W'(i + 1)) begin
                        header_in[8*i +: 8] = tok.data;
                     end
                  end
                  for (int i = 0; i < ebfd_pkg::MAX_PAYLOAD; i++) begin
                     if (count_ff == ebfd_pkg::CNT_W'(ebfd_pkg::HDR_BYTES + 1 + i)) begin
                        store_in[i] = tok.data;
                     end
                  end
                  count_in = count_ff + ebfd_pkg::CNT_W'(1);
                  if (count_ff == length_ff) begin
                     emit        = 1'b1;
                     in_frame_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            in_frame_in = in_frame_ff;
         end
      endcase
   end

   // Payload lanes, first byte lowest, unused lanes zero
   always_comb begin
      pay_vec = '0;
      for (int i = 0; i < ebfd_pkg::MAX_PAYLOAD; i++) begin
         pay_vec[8*i +: 8] = store_in[i];
      end
   end

   assign out_valid_in = (take && emit) || (out_valid_ff && !rsp_tready);

   // Frame state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            in_frame_ff <= in_frame_in;
            count_ff    <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         length_ff <= length_in;
         header_ff <= header_in;
         store_ff  <= store_in;
      end
      if (take && emit) begin
         out_header_ff <= header_in;
         out_len_ff    <= length_ff - ebfd_pkg::LEN_W'(ebfd_pkg::HDR_BYTES);
         out_pay_ff    <= pay_vec;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, out_pay_ff, out_len_ff, out_header_ff};

endmodule

### design/escaped_byte_frame_decoder.sv
// Top level of the escaped byte frame decoder: front end, token queue, back end.
// Depends on ebfd_pkg, ebfd_front, ebfd_queue and ebfd_back.
//
//   channel   dir   width  contents (lowest bit first)
//   req_      in    8      rx_byte
//   rsp_      out   104    header_word[31:0], payload_len[35:32],
//                          payload_bytes[99:36], zero[103:100]
//
// One raw byte is taken per cycle while the queue has space; the front end resolves
// escapes in the accepting cycle and the back end assembles the frame one token per
// cycle while the result register is free or draining. Tokens pass through the queue,
// and the last token of a frame loads the result register, which raises rsp_tvalid.
// The result register and the two-entry queue absorb a stalled rsp_ side;
// req_tready drops only when the queue is full. Synchronous reset, no clearing pass.
`timescale 1ns / 1ps

module escaped_byte_frame_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // rx_byte[7:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ebfd_pkg::RSP_W-1:0] rsp_tdata    // header_word, payload_len, payload_bytes, pad
);

   ebfd_pkg::token_type push_token;
   ebfd_pkg::token_type pop_token;
   logic                push;
   logic                not_full;
   logic                not_empty;
   logic                pop;

   assign req_tready = not_full;

   ebfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .space_avail (not_full),
      .push        (push),
      .push_token  (push_token)
   );

   ebfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .not_full   (not_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_token  (pop_token)
   );

   ebfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (not_empty),
      .tok        (pop_token),
      .tok_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### design/ebfd_checker.sv
// Port-level checks for the escaped byte frame decoder, bound to the top level.
// Depends on ebfd_pkg and escaped_byte_frame_decoder.
`timescale 1ns / 1ps

module ebfd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [7:0]                 req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ebfd_pkg::RSP_W-1:0] rsp_tdata
);

   // No result survives reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Payload length within the frame limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:32] <= 4'(ebfd_pkg::MAX_PAYLOAD))
      else $error("payload length out of range");

   // Last payload lane is zero unless the payload is full, and padding is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35:32] != 4'd8 |->
         rsp_tdata[99:92] == 8'h00 && rsp_tdata[103:100] == 4'h0)
      else $error("unused payload bytes not zero");

   // Handshake and line byte are known while a byte is offered
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown({req_tready, req_tdata}))
      else $error("unknown request handshake or data");

endmodule

bind escaped_byte_frame_decoder ebfd_checker u_ebfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### bench/tb_escaped_byte_frame_decoder.sv
// Self-checking testbench for the escaped byte frame decoder: drives raw line bytes,
// predicts every decoded frame and checks each result transfer field by field.
// Depends on ebfd_pkg and escaped_byte_frame_decoder.
`timescale 1ns / 1ps

module tb_escaped_byte_frame_decoder;

   localparam int ITEM_TARGET   = 850;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int TIMEOUT_NS    = 2_000_000;

   // Result layout, highest field first so the struct matches rsp_tdata bit for bit
   typedef struct packed {
      logic [ebfd_pkg::RSP_W-ebfd_pkg::HDR_W-ebfd_pkg::LEN_W-ebfd_pkg::PAY_W-1:0] pad;
      logic [ebfd_pkg::PAY_W-1:0] payload_bytes;
      logic [ebfd_pkg::LEN_W-1:0] payload_len;
      logic [ebfd_pkg::HDR_W-1:0] header_word;
   } frame_result_type;

   // Frame predictor plus store of decoded frames still to arrive
   class frame_scoreboard;
      bit                         in_frame;
      bit                         esc_pending;
      logic [ebfd_pkg::CNT_W-1:0] byte_count;
      logic [ebfd_pkg::LEN_W-1:0] frame_len;
      logic [ebfd_pkg::HDR_W-1:0] header;
      logic [ebfd_pkg::PAY_W-1:0] payload;
      frame_result_type           frames_due[$];
      int                         errors;

      function void clear_frame();
         esc_pending = 1'b0;
         byte_count  = '0;
         frame_len   = '0;
         header      = '0;
         payload     = '0;
      endfunction

      function new();
         in_frame = 1'b0;
         errors   = 0;
         clear_frame();
      endfunction

      // Advance the decoder state by one accepted line byte
      function void note_byte(logic [7:0] raw);
         logic [7:0]       b;
         int               pos;
         frame_result_type res;
         b = raw;
         if (raw == ebfd_pkg::START_BYTE) begin
            in_frame = 1'b1;
            clear_frame();
            return;
         end
         if (!in_frame) return;
         if (esc_pending) begin
            esc_pending = 1'b0;
            if (raw == ebfd_pkg::ESC_BYTE) b = ebfd_pkg::START_BYTE;
            else if (raw == ebfd_pkg::ESC_FD) b = ebfd_pkg::ESC_BYTE;
            else begin
               in_frame = 1'b0;
               return;
            end
         end else if (raw == ebfd_pkg::ESC_BYTE) begin
            esc_pending = 1'b1;
            return;
         end
         pos = int'(byte_count);
         // first decoded byte is the length
         if (pos == 0) begin
            if (b < ebfd_pkg::HDR_BYTES || b > ebfd_pkg::MAX_LEN) begin
               in_frame = 1'b0;
               return;
            end
            frame_len  = b[ebfd_pkg::LEN_W-1:0];
            byte_count = ebfd_pkg::CNT_W'(1);
            return;
         end
         if (pos <= ebfd_pkg::HDR_BYTES) header[8*(pos-1) +: 8] = b;
         else payload[8*(pos-ebfd_pkg::HDR_BYTES-1) +: 8] = b;
         byte_count = byte_count + 1'b1;
         if (pos == frame_len) begin
            res.pad           = '0;
            res.header_word   = header;
            res.payload_len   = ebfd_pkg::LEN_W'(frame_len - ebfd_pkg::HDR_BYTES);
            res.payload_bytes = payload;
            frames_due.push_back(res);
            in_frame    = 1'b0;
            esc_pending = 1'b0;
         end
      endfunction

      // Compare one result transfer with the oldest predicted frame
      function void check_result(logic [ebfd_pkg::RSP_W-1:0] data);
         frame_result_type got;
         frame_result_type want;
         got = frame_result_type'(data);
         if (frames_due.size() == 0) begin
            $error("unexpected result transfer: %h", data);
            errors++;
            return;
         end
         want = frames_due.pop_front();
         if (got.header_word !== want.header_word) begin
            $error("header_word: expected %h, got %h", want.header_word, got.header_word);
            errors++;
         end
         if (got.payload_len !== want.payload_len) begin
            $error("payload_len: expected %0d, got %0d", want.payload_len, got.payload_len);
            errors++;
         end
         if (got.payload_bytes !== want.payload_bytes) begin
            $error("payload_bytes: expected %h, got %h",
                   want.payload_bytes, got.payload_bytes);
            errors++;
         end
         if (got.pad !== want.pad) begin
            $error("pad: expected %h, got %h", want.pad, got.pad);
            errors++;
         end
      endfunction

      function int waiting();
         return frames_due.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [ebfd_pkg::RSP_W-1:0] rsp_tdata;

   frame_scoreboard  sb = new();

   bit               hold_request = 1'b0;
   bit               no_gaps = 1'b0;
   bit               noise = 1'b0;
   int               burst_left = 0;
   int               items_sent = 0;
   logic [7:0]       frame_body[$];

   escaped_byte_frame_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe both channels at the edge where a transfer completes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Offer one raw byte and wait for its transfer; gaps fall between bursts
   task automatic send_byte(input logic [7:0] raw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!noise) items_sent++;
   endtask

   // Send one decoded byte, escaping the two reserved values
   task automatic send_data(input logic [7:0] d);
      if (d == ebfd_pkg::START_BYTE) begin
         send_byte(ebfd_pkg::ESC_BYTE);
         send_byte(ebfd_pkg::ESC_BYTE);
      end else if (d == ebfd_pkg::ESC_BYTE) begin
         send_byte(ebfd_pkg::ESC_BYTE);
         send_byte(ebfd_pkg::ESC_FD);
      end else begin
         send_byte(d);
      end
   endtask

   // Start byte, length byte, then whatever frame_body holds
   task automatic send_frame(input int len);
      send_byte(ebfd_pkg::START_BYTE);
      send_data(len[7:0]);
      foreach (frame_body[i]) send_data(frame_body[i]);
   endtask

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 7))
         0: return ebfd_pkg::START_BYTE;
         1: return ebfd_pkg::ESC_BYTE;
         2: return ebfd_pkg::ESC_FD;
         3: return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void fill_body(input int n);
      frame_body.delete();
      repeat (n) frame_body.push_back(pick_data());
   endfunction

   // Stop offering bytes until every predicted frame has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.waiting() != 0);
   endtask

   // Receiver: changing stall patterns, plus a long hold-off on request
   initial begin : receiver
      int rx_mode;
      int mode_left;
      int hold_left;
      int rx_cycle;
      rx_mode   = 0;
      mode_left = 0;
      hold_left = 0;
      rx_cycle  = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 200);
         end
         mode_left--;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ((rx_cycle % 7) < 3);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   initial begin : stimulus
      int frame_no;
      int len;
      int choice;
      int k;
      frame_no = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: bytes outside a frame, both bad lengths, an escaped length
      send_byte(8'h00);
      send_byte(ebfd_pkg::ESC_FD);
      send_byte(ebfd_pkg::START_BYTE);
      send_byte(8'h03);
      send_byte(ebfd_pkg::START_BYTE);
      send_byte(8'h0D);
      send_byte(ebfd_pkg::START_BYTE);
      send_byte(ebfd_pkg::ESC_BYTE);
      send_byte(ebfd_pkg::ESC_FD);
      // shortest frame, header made of the three special line bytes and a zero, then a stray byte
      frame_body = '{ebfd_pkg::START_BYTE, ebfd_pkg::ESC_BYTE, ebfd_pkg::ESC_FD, 8'h00};
      send_frame(ebfd_pkg::HDR_BYTES);
      send_byte(8'h55);
      // bad escape aborts
      send_byte(ebfd_pkg::START_BYTE);
      send_byte(8'h06);
      send_byte(ebfd_pkg::ESC_BYTE);
      send_byte(8'h41);
      // start right after an escape, then the longest frame
      send_byte(ebfd_pkg::START_BYTE);
      send_byte(8'h08);
      send_byte(ebfd_pkg::ESC_BYTE);
      frame_body = '{8'h00, 8'h7F, 8'h80, ebfd_pkg::START_BYTE,
                     8'hFF, 8'h01, ebfd_pkg::ESC_BYTE, ebfd_pkg::ESC_FD,
                     8'h00, 8'hAA, 8'h55, 8'h80};
      send_frame(ebfd_pkg::MAX_LEN);
      drain();

      // Random: mostly well-formed frames, some broken ones and line noise
      while (items_sent < ITEM_TARGET) begin
         frame_no++;
         if (frame_no == 40) begin
            // receiver holds off while short frames arrive back to back
            hold_request = 1'b1;
            no_gaps      = 1'b1;
            burst_left   = 0;
            repeat (16) begin
               len = $urandom_range(ebfd_pkg::HDR_BYTES, ebfd_pkg::HDR_BYTES + 2);
               fill_body(len);
               send_frame(len);
            end
            no_gaps = 1'b0;
            drain();
         end
         len    = $urandom_range(ebfd_pkg::HDR_BYTES, ebfd_pkg::MAX_LEN);
         choice = $urandom_range(0, 9);
         fill_body(len);
         if (choice < 7) begin
            send_frame(len);
            if ($urandom_range(0, 4) == 0) begin
               noise = 1'b1;
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
               noise = 1'b0;
            end
         end else if (choice == 7) begin
            // length out of range
            send_byte(ebfd_pkg::START_BYTE);
            if ($urandom_range(0, 1) == 0) begin
               send_data(8'($urandom_range(0, ebfd_pkg::HDR_BYTES - 1)));
            end else begin
               send_data(8'($urandom_range(ebfd_pkg::MAX_LEN + 1, 255)));
            end
            noise = 1'b1;
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 254)));
            noise = 1'b0;
         end else if (choice == 8) begin
            // escape followed by a byte it cannot decode
            k = $urandom_range(0, len - 1);
            frame_body = frame_body[0:k];
            frame_body.pop_back();
            send_frame(len);
            send_byte(ebfd_pkg::ESC_BYTE);
            send_byte(8'($urandom_range(0, ebfd_pkg::ESC_FD - 1)));
         end else begin
            // frame cut short, sometimes mid escape; the next start ends it
            k = $urandom_range(0, len - 1);
            frame_body = frame_body[0:k];
            frame_body.pop_back();
            send_frame(len);
            if ($urandom_range(0, 1) == 0) send_byte(ebfd_pkg::ESC_BYTE);
         end
         if ($urandom_range(0, 39) == 0) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
design/ebfd_pkg.sv
design/ebfd_front.sv
design/ebfd_queue.sv
design/ebfd_back.sv
design/escaped_byte_frame_decoder.sv
design/ebfd_checker.sv
bench/tb_escaped_byte_frame_decoder.sv
